FILE: rtl/spbp_pkg.sv
package spbp_pkg;

    // Significant bits of each input bound; higher bits are ignored.
    localparam int BOUND_WIDTH = 32;

    // Fixed field widths.
    localparam int FW          = 32;
    localparam int LIMIT_HI_W  = FW - 1;
    localparam int NUM_W       = FW + 2;   // signed quotient operands and results
    localparam int MAG_W       = FW + 1;   // dividend magnitude, quotient bits
    localparam int DEN_W       = FW;       // divisor magnitude
    localparam int PROD_W      = 2 * FW;

    // Pipeline depths.
    localparam int ZSTAGE_LAT  = 3;
    localparam int PREP_LAT    = 2;
    localparam int DIV_LAT     = MAG_W + 1;
    localparam int SIDE_LAT    = PREP_LAT + DIV_LAT;
    localparam int TOTAL_LAT   = 1 + ZSTAGE_LAT + SIDE_LAT + 2;

    localparam int CFG_IDX_W   = 1;

    typedef logic signed [FW-1:0]     bound_t;
    typedef logic signed [NUM_W-1:0]  wide_t;
    typedef logic signed [PROD_W-1:0] prod_t;

    localparam wide_t WIDE_ZERO      = '0;
    localparam wide_t WIDE_ONE       = wide_t'(1);
    localparam wide_t WIDE_MINUS_ONE = wide_t'(-1);

    localparam bound_t               LIMIT_LOW_RST  = bound_t'(-500000000);
    localparam logic [LIMIT_HI_W-1:0] LIMIT_HIGH_RST = LIMIT_HI_W'(500000000);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LIMIT_LOW  = 1'b0,
        CFG_LIMIT_HIGH = 1'b1
    } cfg_idx_t;

    typedef struct packed {
        bound_t x_lo;
        bound_t x_hi;
        bound_t y_lo;
        bound_t y_hi;
        bound_t z_lo;
        bound_t z_hi;
        logic   failed;
    } bounds_t;

    // Case selection for tightening one factor.
    typedef struct packed {
        logic             zprod;
        logic             fix_zero;
        logic             pass;
        logic             vmin_zero;
        logic             vmax_zero;
        logic             straddle;
        logic [DEN_W-1:0] smax;
    } tf_ctl_t;

    typedef struct packed {
        logic [MAG_W-1:0] num;
        logic [DEN_W-1:0] den;
        logic             neg;
    } div_req_t;

endpackage

FILE: rtl/spbp_zstage.sv
module spbp_zstage
    import spbp_pkg::*;
(
    input  logic                  clk,
    input  logic                  en,
    input  bounds_t               b_in,
    input  bound_t                limit_low,
    input  logic [LIMIT_HI_W-1:0] limit_high,
    output bounds_t               b_out
);

    bounds_t b1_reg;
    bounds_t b2_reg;
    bounds_t b3_reg;
    bounds_t b3_next;
    prod_t   p_reg [4];
    prod_t   zlo_reg;
    prod_t   zhi_reg;
    prod_t   zlo_next;
    prod_t   zhi_next;

    // Corner products.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b1_reg   <= b_in;
            p_reg[0] <= prod_t'($signed(b_in.x_lo)) * prod_t'($signed(b_in.y_lo));
            p_reg[1] <= prod_t'($signed(b_in.x_lo)) * prod_t'($signed(b_in.y_hi));
            p_reg[2] <= prod_t'($signed(b_in.x_hi)) * prod_t'($signed(b_in.y_lo));
            p_reg[3] <= prod_t'($signed(b_in.x_hi)) * prod_t'($signed(b_in.y_hi));
        end
    end

    always_comb
    begin
        prod_t mn0;
        prod_t mn1;
        prod_t mx0;
        prod_t mx1;
        mn0      = (p_reg[0] < p_reg[1]) ? p_reg[0] : p_reg[1];
        mn1      = (p_reg[2] < p_reg[3]) ? p_reg[2] : p_reg[3];
        mx0      = (p_reg[0] > p_reg[1]) ? p_reg[0] : p_reg[1];
        mx1      = (p_reg[2] > p_reg[3]) ? p_reg[2] : p_reg[3];
        zlo_next = (mn0 < mn1) ? mn0 : mn1;
        zhi_next = (mx0 > mx1) ? mx0 : mx1;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b2_reg  <= b1_reg;
            zlo_reg <= zlo_next;
            zhi_reg <= zhi_next;
        end
    end

    // Apply the product range to z inside the limits; stop at a crossing.
    always_comb
    begin
        prod_t lo;
        prod_t hi;
        prod_t lim_lo;
        prod_t lim_hi;
        logic  fail;
        lo      = prod_t'($signed(b2_reg.z_lo));
        hi      = prod_t'($signed(b2_reg.z_hi));
        lim_lo  = prod_t'(limit_low);
        lim_hi  = prod_t'({1'b0, limit_high});
        fail    = 1'b0;
        b3_next = b2_reg;
        if (zlo_reg > lim_lo)
        begin
            priority if (zlo_reg <= lo)
            begin
                lo = lo;
            end
            else if (zlo_reg > hi)
            begin
                fail = 1'b1;
            end
            else
            begin
                lo = zlo_reg;
            end
        end
        if (!fail && (zhi_reg < lim_hi))
        begin
            priority if (zhi_reg >= hi)
            begin
                hi = hi;
            end
            else if (zhi_reg < lo)
            begin
                fail = 1'b1;
            end
            else
            begin
                hi = zhi_reg;
            end
        end
        b3_next.z_lo   = lo[FW-1:0];
        b3_next.z_hi   = hi[FW-1:0];
        b3_next.failed = fail;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b3_reg <= b3_next;
        end
    end

    assign b_out = b3_reg;

endmodule

FILE: rtl/spbp_prep.sv
module spbp_prep
    import spbp_pkg::*;
(
    input  logic     clk,
    input  logic     en,
    input  bound_t   vmin,
    input  bound_t   vmax,
    input  bound_t   zmin,
    input  bound_t   zmax,
    output div_req_t qmin_req,
    output div_req_t qmax_req,
    output tf_ctl_t  ctl
);

    wide_t            nmin_num_reg;
    wide_t            nmin_den_reg;
    wide_t            nmax_num_reg;
    wide_t            nmax_den_reg;
    wide_t            nmin_num_next;
    wide_t            nmin_den_next;
    wide_t            nmax_num_next;
    wide_t            nmax_den_next;
    logic [DEN_W-1:0] zmin_abs_reg;
    logic [DEN_W-1:0] zmax_abs_reg;
    tf_ctl_t          ctl1_reg;
    tf_ctl_t          ctl1_next;
    div_req_t         qmin_reg;
    div_req_t         qmax_reg;
    tf_ctl_t          ctl2_reg;
    tf_ctl_t          ctl2_next;

    // Build signed dividends and divisors for the ceil and floor quotients.
    always_comb
    begin
        wide_t vl;
        wide_t vh;
        wide_t zl;
        wide_t zh;
        vl = wide_t'(vmin);
        vh = wide_t'(vmax);
        zl = wide_t'(zmin);
        zh = wide_t'(zmax);
        if (vh < 0)
        begin
            if (zl > 0)
            begin
                nmin_num_next = zh - vh - WIDE_ONE;
                nmin_den_next = vh;
            end
            else
            begin
                nmin_num_next = -zh - vl - WIDE_ONE;
                nmin_den_next = -vl;
            end
        end
        else if (vl > 0)
        begin
            if (zl > 0)
            begin
                nmin_num_next = zl + vh - WIDE_ONE;
                nmin_den_next = vh;
            end
            else
            begin
                nmin_num_next = -zl + vl - WIDE_ONE;
                nmin_den_next = -vl;
            end
        end
        else
        begin
            nmin_num_next = WIDE_ZERO;
            nmin_den_next = WIDE_ONE;
        end
        nmax_num_next = (vh < 0) ? zl : zh;
        nmax_den_next = (zl > 0) ? vl : vh;

        ctl1_next.zprod     = (zmin == 0) && (zmax == 0);
        ctl1_next.fix_zero  = (vmin > 0) || (vmax < 0);
        ctl1_next.pass      = !((zmin > 0) || (zmax < 0));
        ctl1_next.vmin_zero = (vmin == 0);
        ctl1_next.vmax_zero = (vmax == 0);
        ctl1_next.straddle  = (vmin < 0) && (vmax > 0);
        ctl1_next.smax      = '0;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            nmin_num_reg <= nmin_num_next;
            nmin_den_reg <= nmin_den_next;
            nmax_num_reg <= nmax_num_next;
            nmax_den_reg <= nmax_den_next;
            zmin_abs_reg <= (zmin < 0) ? DEN_W'(-wide_t'(zmin)) : DEN_W'(zmin);
            zmax_abs_reg <= (zmax < 0) ? DEN_W'(-wide_t'(zmax)) : DEN_W'(zmax);
            ctl1_reg     <= ctl1_next;
        end
    end

    // Fold the larger z magnitude into the case flags.
    always_comb
    begin
        ctl2_next      = ctl1_reg;
        ctl2_next.smax = (zmin_abs_reg > zmax_abs_reg) ? zmin_abs_reg : zmax_abs_reg;
    end

    // Split into magnitudes and result sign.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            qmin_reg.num  <= (nmin_num_reg < 0) ? MAG_W'(-nmin_num_reg) : MAG_W'(nmin_num_reg);
            qmin_reg.den  <= (nmin_den_reg < 0) ? DEN_W'(-nmin_den_reg) : DEN_W'(nmin_den_reg);
            qmin_reg.neg  <= nmin_num_reg[NUM_W-1] ^ nmin_den_reg[NUM_W-1];
            qmax_reg.num  <= (nmax_num_reg < 0) ? MAG_W'(-nmax_num_reg) : MAG_W'(nmax_num_reg);
            qmax_reg.den  <= (nmax_den_reg < 0) ? DEN_W'(-nmax_den_reg) : DEN_W'(nmax_den_reg);
            qmax_reg.neg  <= nmax_num_reg[NUM_W-1] ^ nmax_den_reg[NUM_W-1];
            ctl2_reg      <= ctl2_next;
        end
    end

    assign qmin_req = qmin_reg;
    assign qmax_req = qmax_reg;
    assign ctl      = ctl2_reg;

endmodule

FILE: rtl/spbp_div.sv
module spbp_div
    import spbp_pkg::*;
(
    input  logic     clk,
    input  logic     en,
    input  div_req_t req,
    output wide_t    quo
);

    // One quotient bit per stage, restoring.
    logic [DEN_W-1:0] rem_reg [MAG_W];
    logic [MAG_W-1:0] num_reg [MAG_W];
    logic [DEN_W-1:0] den_reg [MAG_W];
    logic             neg_reg [MAG_W];
    wide_t            quo_reg;

    for (genvar k = 0; k < MAG_W; k++)
    begin : g_step
        logic [DEN_W-1:0] rem_in;
        logic [MAG_W-1:0] num_in;
        logic [DEN_W-1:0] den_in;
        logic             neg_in;
        logic [DEN_W:0]   trial;
        logic [DEN_W:0]   diff;
        logic             ge;

        if (k == 0)
        begin : g_first
            assign rem_in = '0;
            assign num_in = req.num;
            assign den_in = req.den;
            assign neg_in = req.neg;
        end
        else
        begin : g_next
            assign rem_in = rem_reg[k-1];
            assign num_in = num_reg[k-1];
            assign den_in = den_reg[k-1];
            assign neg_in = neg_reg[k-1];
        end

        assign trial = {rem_in, num_in[MAG_W-1]};
        assign diff  = trial - {1'b0, den_in};
        assign ge    = (trial >= {1'b0, den_in});

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k] <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
                num_reg[k] <= {num_in[MAG_W-2:0], ge};
                den_reg[k] <= den_in;
                neg_reg[k] <= neg_in;
            end
        end
    end

    // Restore the sign; truncation toward zero follows from the magnitudes.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            quo_reg <= neg_reg[MAG_W-1] ? -wide_t'({1'b0, num_reg[MAG_W-1]})
                                        :  wide_t'({1'b0, num_reg[MAG_W-1]});
        end
    end

    assign quo = quo_reg;

endmodule

FILE: rtl/spbp_tighten.sv
module spbp_tighten
    import spbp_pkg::*;
(
    input  logic    clk,
    input  logic    en,
    input  logic    sel_y,
    input  bounds_t b_in,
    input  tf_ctl_t ctl,
    input  wide_t   qmin,
    input  wide_t   qmax,
    output bounds_t b_out
);

    bounds_t b_reg;
    bounds_t b_next;

    always_comb
    begin
        wide_t ulo;
        wide_t uhi;
        wide_t vlo;
        wide_t vhi;
        wide_t nmin;
        wide_t nmax;
        wide_t val;
        logic  fail;
        ulo  = sel_y ? wide_t'(b_in.y_lo) : wide_t'(b_in.x_lo);
        uhi  = sel_y ? wide_t'(b_in.y_hi) : wide_t'(b_in.x_hi);
        vlo  = sel_y ? wide_t'(b_in.x_lo) : wide_t'(b_in.y_lo);
        vhi  = sel_y ? wide_t'(b_in.x_hi) : wide_t'(b_in.y_hi);
        nmin = ctl.straddle ? -wide_t'({1'b0, ctl.smax}) : qmin;
        nmax = ctl.straddle ?  wide_t'({1'b0, ctl.smax}) : qmax;
        val  = WIDE_ZERO;
        fail = b_in.failed;

        priority if (b_in.failed || ctl.pass && !ctl.zprod)
        begin
            fail = b_in.failed;
        end
        else if (ctl.zprod)
        begin
            if (ctl.fix_zero)
            begin
                // Fix the factor at zero.
                if (WIDE_ZERO > ulo)
                begin
                    if (WIDE_ZERO > uhi)
                        fail = 1'b1;
                    else
                        ulo = WIDE_ZERO;
                end
                if (!fail && (WIDE_ZERO < uhi))
                begin
                    if (WIDE_ZERO < ulo)
                        fail = 1'b1;
                    else
                        uhi = WIDE_ZERO;
                end
            end
        end
        else if (ctl.vmin_zero)
        begin
            // Exclude zero from the divisor.
            if (WIDE_ONE > vlo)
            begin
                if (WIDE_ONE > vhi)
                    fail = 1'b1;
                else
                    vlo = WIDE_ONE;
            end
        end
        else if (ctl.vmax_zero)
        begin
            if (WIDE_MINUS_ONE < vhi)
            begin
                if (WIDE_MINUS_ONE < vlo)
                    fail = 1'b1;
                else
                    vhi = WIDE_MINUS_ONE;
            end
        end
        else
        begin
            if (nmin > ulo)
            begin
                val = (nmin == WIDE_ZERO) ? WIDE_ONE : nmin;
                if (val > ulo)
                begin
                    if (val > uhi)
                        fail = 1'b1;
                    else
                        ulo = val;
                end
            end
            if (!fail && (nmax < uhi))
            begin
                val = (nmax == WIDE_ZERO) ? WIDE_MINUS_ONE : nmax;
                if (val < uhi)
                begin
                    if (val < ulo)
                        fail = 1'b1;
                    else
                        uhi = val;
                end
            end
        end

        b_next        = b_in;
        b_next.failed = fail;
        if (sel_y)
        begin
            b_next.y_lo = ulo[FW-1:0];
            b_next.y_hi = uhi[FW-1:0];
            b_next.x_lo = vlo[FW-1:0];
            b_next.x_hi = vhi[FW-1:0];
        end
        else
        begin
            b_next.x_lo = ulo[FW-1:0];
            b_next.x_hi = uhi[FW-1:0];
            b_next.y_lo = vlo[FW-1:0];
            b_next.y_hi = vhi[FW-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b_reg <= b_next;
        end
    end

    assign b_out = b_reg;

endmodule

FILE: rtl/signed_product_bounds_propagator.sv
// Bounds propagator for x * y = z over signed integer intervals.
//
// Input channel: in_valid / in_stall with the six current bounds. A transaction
// completes on a clock edge with in_valid high and in_stall low.
// Output channel: out_valid / out_stall with the six tightened bounds and the
// failed flag; the receiver holds out_stall high to keep a result waiting.
// Config channel: cfg_valid / cfg_ready (always ready) with cfg_index and
// cfg_data; index 0 is limit_low, index 1 is limit_high (low 31 bits). Write
// only while no transaction is in flight.
//
// While no result is stalled, one transaction per cycle is accepted; each goes
// through the input register, corner multiply, min/max, z update, two divisor
// prep stages, a 33-step restoring divider plus sign stage, and one stage for
// each factor. The divider depth sets the latency.
// A stalled result freezes the whole pipeline together, so in_stall follows
// out_stall while a result waits; nothing is dropped or repeated.
// Reset clears all valid bits and returns the limits to -500000000 and
// 500000000.
module signed_product_bounds_propagator
    import spbp_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,

    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic signed [FW-1:0] x_lo,
    input  logic signed [FW-1:0] x_hi,
    input  logic signed [FW-1:0] y_lo,
    input  logic signed [FW-1:0] y_hi,
    input  logic signed [FW-1:0] z_lo,
    input  logic signed [FW-1:0] z_hi,

    output logic                 out_valid,
    input  logic                 out_stall,
    output logic signed [FW-1:0] x_lo_new,
    output logic signed [FW-1:0] x_hi_new,
    output logic signed [FW-1:0] y_lo_new,
    output logic signed [FW-1:0] y_hi_new,
    output logic signed [FW-1:0] z_lo_new,
    output logic signed [FW-1:0] z_hi_new,
    output logic                 failed,

    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [FW-1:0]        cfg_data
);

    logic                  adv;
    bound_t                limit_low_reg;
    bound_t                limit_low_next;
    logic [LIMIT_HI_W-1:0] limit_high_reg;
    logic [LIMIT_HI_W-1:0] limit_high_next;
    logic [TOTAL_LAT-1:0]  vld_reg;

    bounds_t  in_reg;
    bounds_t  in_next;
    bounds_t  zb;
    bounds_t  side_reg [SIDE_LAT];
    div_req_t qx_min_req;
    div_req_t qx_max_req;
    div_req_t qy_min_req;
    div_req_t qy_max_req;
    tf_ctl_t  ctl_x;
    tf_ctl_t  ctl_y;
    tf_ctl_t  ctl_x_reg [DIV_LAT];
    tf_ctl_t  ctl_y_reg [DIV_LAT+1];
    wide_t    qx_min;
    wide_t    qx_max;
    wide_t    qy_min;
    wide_t    qy_max;
    wide_t    qy_min_reg;
    wide_t    qy_max_reg;
    bounds_t  bx;
    bounds_t  by;

    // Advance everything unless a finished result is held by the receiver.
    assign adv       = !vld_reg[TOTAL_LAT-1] || !out_stall;
    assign in_stall  = !adv;
    assign cfg_ready = 1'b1;

    // Limit registers.
    always_comb
    begin
        limit_low_next  = limit_low_reg;
        limit_high_next = limit_high_reg;
        if (cfg_valid)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_LIMIT_LOW:  limit_low_next  = bound_t'(cfg_data);
                CFG_LIMIT_HIGH: limit_high_next = cfg_data[LIMIT_HI_W-1:0];
                default:        limit_low_next  = limit_low_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_low_reg  <= LIMIT_LOW_RST;
            limit_high_reg <= LIMIT_HIGH_RST;
            vld_reg        <= '0;
        end
        else
        begin
            limit_low_reg  <= limit_low_next;
            limit_high_reg <= limit_high_next;
            if (adv)
            begin
                vld_reg <= {vld_reg[TOTAL_LAT-2:0], in_valid};
            end
        end
    end

    // Drop bits above the bound width and sign-extend.
    always_comb
    begin
        in_next.x_lo   = bound_t'($signed(x_lo[BOUND_WIDTH-1:0]));
        in_next.x_hi   = bound_t'($signed(x_hi[BOUND_WIDTH-1:0]));
        in_next.y_lo   = bound_t'($signed(y_lo[BOUND_WIDTH-1:0]));
        in_next.y_hi   = bound_t'($signed(y_hi[BOUND_WIDTH-1:0]));
        in_next.z_lo   = bound_t'($signed(z_lo[BOUND_WIDTH-1:0]));
        in_next.z_hi   = bound_t'($signed(z_hi[BOUND_WIDTH-1:0]));
        in_next.failed = 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            in_reg <= in_next;
        end
    end

    spbp_zstage u_zstage (
        .clk        (clk),
        .en         (adv),
        .b_in       (in_reg),
        .limit_low  (limit_low_reg),
        .limit_high (limit_high_reg),
        .b_out      (zb)
    );

    // Divisor prep for x (divisor y) and for y (divisor x), original factors.
    spbp_prep u_prep_x (
        .clk      (clk),
        .en       (adv),
        .vmin     (zb.y_lo),
        .vmax     (zb.y_hi),
        .zmin     (zb.z_lo),
        .zmax     (zb.z_hi),
        .qmin_req (qx_min_req),
        .qmax_req (qx_max_req),
        .ctl      (ctl_x)
    );

    spbp_prep u_prep_y (
        .clk      (clk),
        .en       (adv),
        .vmin     (zb.x_lo),
        .vmax     (zb.x_hi),
        .zmin     (zb.z_lo),
        .zmax     (zb.z_hi),
        .qmin_req (qy_min_req),
        .qmax_req (qy_max_req),
        .ctl      (ctl_y)
    );

    spbp_div u_div_x_min (.clk(clk), .en(adv), .req(qx_min_req), .quo(qx_min));
    spbp_div u_div_x_max (.clk(clk), .en(adv), .req(qx_max_req), .quo(qx_max));
    spbp_div u_div_y_min (.clk(clk), .en(adv), .req(qy_min_req), .quo(qy_min));
    spbp_div u_div_y_max (.clk(clk), .en(adv), .req(qy_max_req), .quo(qy_max));

    // Carry bounds and case flags alongside the dividers.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            side_reg[0]  <= zb;
            ctl_x_reg[0] <= ctl_x;
            ctl_y_reg[0] <= ctl_y;
            for (int k = 1; k < SIDE_LAT; k++)
            begin
                side_reg[k] <= side_reg[k-1];
            end
            for (int k = 1; k < DIV_LAT; k++)
            begin
                ctl_x_reg[k] <= ctl_x_reg[k-1];
            end
            for (int k = 1; k < DIV_LAT + 1; k++)
            begin
                ctl_y_reg[k] <= ctl_y_reg[k-1];
            end
            qy_min_reg <= qy_min;
            qy_max_reg <= qy_max;
        end
    end

    // Tighten x first, then y from the bounds x leaves behind.
    spbp_tighten u_tighten_x (
        .clk   (clk),
        .en    (adv),
        .sel_y (1'b0),
        .b_in  (side_reg[SIDE_LAT-1]),
        .ctl   (ctl_x_reg[DIV_LAT-1]),
        .qmin  (qx_min),
        .qmax  (qx_max),
        .b_out (bx)
    );

    spbp_tighten u_tighten_y (
        .clk   (clk),
        .en    (adv),
        .sel_y (1'b1),
        .b_in  (bx),
        .ctl   (ctl_y_reg[DIV_LAT]),
        .qmin  (qy_min_reg),
        .qmax  (qy_max_reg),
        .b_out (by)
    );

    assign out_valid = vld_reg[TOTAL_LAT-1];
    assign x_lo_new  = by.x_lo;
    assign x_hi_new  = by.x_hi;
    assign y_lo_new  = by.y_lo;
    assign y_hi_new  = by.y_hi;
    assign z_lo_new  = by.z_lo;
    assign z_hi_new  = by.z_hi;
    assign failed    = by.failed;

endmodule
